FILE: rtl/core/olad_pkg.sv
// shared constants for the ordered list append/delete block
// command and status codes, store depth and derived widths; no dependencies
package olad_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

FILE: rtl/core/ordered_list_append_delete.sv
// append, full, empty and single-status beats go through the S_RESP state to the output register
// delete scans every held entry (one entry read per cycle through the store ram)
// dump streams one beat per cycle, slowed only by out_stall_i
// one command in flight; a new beat is taken once the previous command has finished
// rst_ni (async, active low) empties the store and drops all valids; ram contents persist
// top level of the ordered list; uses olad_pkg
module ordered_list_append_delete
  import olad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] operand_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_of_run_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DUMP,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  // store: entries held from index 0 (head) up to occupancy - 1 (tail)
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_q;

  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;     // next address to read
  logic [IDX_W-1:0]   didx_q, didx_d;   // index of the entry now in rdata_q
  logic               dvld_q, dvld_d;   // rdata_q holds an unconsumed entry
  logic               found_q, found_d; // delete key matched, shifting up
  logic signed [31:0] key_q, key_d;
  logic [1:0]         res_q, res_d;

  logic               out_vld_q, out_vld_d;
  logic [1:0]         out_status_q, out_status_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic               out_last_q, out_last_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;

  logic               out_free;
  logic               emit;
  logic               hit;
  logic [IDX_W-1:0]   last_idx;

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign entry_value_o = out_value_q;
  assign last_of_run_o = out_last_q;

  // output register can take a beat when empty or being drained this cycle
  assign out_free  = !out_vld_q || !out_stall_i;
  assign last_idx  = IDX_W'(occ_q - CNT_W'(1));
  assign hit       = (rdata_q == key_q);
  assign mem_raddr = ptr_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    ptr_d        = ptr_q;
    didx_d       = didx_q;
    dvld_d       = dvld_q;
    found_d      = found_q;
    key_d        = key_q;
    res_d        = res_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rdata_q;
    mem_re       = 1'b0;
    emit         = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d   = operand_value_i;
          ptr_d   = '0;
          dvld_d  = 1'b0;
          found_d = 1'b0;
          case (cmd_i)
            CMD_APPEND: begin
              // write the new tail straight away
              if (occ_q < CNT_W'(CAPACITY)) begin
                mem_we    = 1'b1;
                mem_waddr = occ_q[IDX_W-1:0];
                mem_wdata = operand_value_i;
                occ_d     = occ_q + CNT_W'(1);
                res_d     = ST_OK;
              end else begin
                res_d     = ST_FULL;
              end
              state_d = S_RESP;
            end
            CMD_DELETE: begin
              if (occ_q == '0) begin
                res_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_DUMP: begin
              if (occ_q == '0) begin
                res_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_DUMP;
              end
            end
            default: ;  // unused code, dropped without a result
          endcase
        end
      end

      S_SCAN: begin
        // stream reads head to tail; after the first hit each entry moves up one slot.
        // the write lands two addresses behind the read, so no forwarding is needed
        if (ptr_q < occ_q) begin
          mem_re = 1'b1;
          ptr_d  = ptr_q + CNT_W'(1);
          didx_d = ptr_q[IDX_W-1:0];
        end
        dvld_d = mem_re;
        if (dvld_q) begin
          if (found_q) begin
            mem_we    = 1'b1;
            mem_waddr = didx_q - IDX_W'(1);
            mem_wdata = rdata_q;
          end else if (hit) begin
            found_d = 1'b1;
          end
          if (didx_q == last_idx) begin
            if (found_q || hit) begin
              occ_d = occ_q - CNT_W'(1);
              res_d = ST_OK;
            end else begin
              res_d = ST_NOTFOUND;
            end
            state_d = S_RESP;
          end
        end
      end

      S_DUMP: begin
        // one-deep read pipe; rdata_q holds while the output is stalled
        emit = dvld_q && out_free;
        if (emit) begin
          out_vld_d    = 1'b1;
          out_status_d = ST_OK;
          out_value_d  = rdata_q;
          out_last_d   = (didx_q == last_idx);
          if (didx_q == last_idx) begin
            state_d = S_IDLE;
          end
        end
        if ((ptr_q < occ_q) && (!dvld_q || emit)) begin
          mem_re = 1'b1;
          ptr_d  = ptr_q + CNT_W'(1);
          didx_d = ptr_q[IDX_W-1:0];
        end
        dvld_d = mem_re || (dvld_q && !emit);
      end

      S_RESP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_q;
          out_value_d  = key_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      ptr_q        <= '0;
      didx_q       <= '0;
      dvld_q       <= 1'b0;
      found_q      <= 1'b0;
      res_q        <= ST_OK;
      out_vld_q    <= 1'b0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      ptr_q        <= ptr_d;
      didx_q       <= didx_d;
      dvld_q       <= dvld_d;
      found_q      <= found_d;
      res_q        <= res_d;
      out_vld_q    <= out_vld_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    out_value_q <= out_value_d;
  end

  // store ram: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

FILE: rtl/core/olad_chk.sv
// port-level checks for ordered_list_append_delete, bound to the top level
// uses olad_pkg for command and status codes
module olad_chk
  import olad_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         cmd_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] entry_value_o,
  input logic               last_of_run_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_value_o) && $stable(last_of_run_o))
    else $error("output beat changed while stalled");

  // a valid command keeps the input stalled while it is worked on
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o
      && (cmd_i == CMD_APPEND || cmd_i == CMD_DELETE || cmd_i == CMD_DUMP)
      |=> in_stall_o)
    else $error("input taken again before command finished");

  // error status only ever comes as a single closing beat
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_of_run_o)
    else $error("error status without last_of_run");

  // mid-run dump beats keep the input stalled
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("input open during a dump run");

endmodule

bind ordered_list_append_delete olad_chk u_olad_chk (.*);

FILE: dv/ordered_list_append_delete_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for ordered_list_append_delete: random valid/stall traffic,
// an in-bench list predictor and an in-order beat checker; depends on olad_pkg and the rtl
module ordered_list_append_delete_tb;
  import olad_pkg::*;

  // cmd code the block must ignore without producing a beat
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int unsigned RAND_CMDS   = 275;
  localparam int unsigned QUIET_TAIL  = 30;     // last commands run with no idling
  localparam int unsigned LONG_HOLD   = 200;    // receiver hold-off that fills the block
  localparam int unsigned IDLE_LIMIT  = 4000;   // watchdog: cycles with no beat on either side
  localparam int unsigned TAIL_CYCLES = 2 * CAPACITY + 8;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] operand;
    logic        drain;   // sender waits for every owed beat before offering this one
  } list_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic        last;
  } list_beat_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i           = CMD_APPEND;
  logic signed [31:0] operand_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] entry_value_o;
  logic               last_of_run_o;

  ordered_list_append_delete dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .operand_value_i (operand_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_value_o   (entry_value_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // commands waiting to be offered, and beats the block still owes us
  list_cmd_t   pending_cmds[$];
  list_beat_t  owed_beats[$];
  logic [31:0] appended_pool[$];   // recent append values, so deletes mostly hit

  // predictor copy of the store
  logic [31:0] held_vals[CAPACITY];
  int unsigned held_cnt = 0;

  int errors = 0;
  int cmds_taken = 0, beats_seen = 0;
  int n_append = 0, n_delete = 0, n_dump = 0, n_spare = 0;
  int n_full = 0, n_del_empty = 0, n_notfound = 0, n_dump_empty = 0;

  function automatic void owe_beat(logic [1:0] status, logic [31:0] value, logic last);
    list_beat_t b;
    b.status = status;
    b.value  = value;
    b.last   = last;
    owed_beats.push_back(b);
  endfunction

  // apply one accepted command to the predicted store and queue the beats it causes
  function automatic void list_apply(logic [1:0] op, logic [31:0] key);
    int hit;
    hit = -1;
    case (op)
      CMD_APPEND: begin
        n_append++;
        if (held_cnt >= CAPACITY) begin
          n_full++;
          owe_beat(ST_FULL, key, 1'b1);
        end else begin
          held_vals[held_cnt] = key;
          held_cnt++;
          owe_beat(ST_OK, key, 1'b1);
        end
      end
      CMD_DELETE: begin
        n_delete++;
        if (held_cnt == 0) begin
          n_del_empty++;
          owe_beat(ST_EMPTY, key, 1'b1);
        end else begin
          // first match from the head only
          for (int i = 0; i < held_cnt; i++) begin
            if (hit < 0 && held_vals[i] == key) hit = i;
          end
          if (hit < 0) begin
            n_notfound++;
            owe_beat(ST_NOTFOUND, key, 1'b1);
          end else begin
            // later entries close the gap
            for (int i = hit; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i + 1];
            held_cnt--;
            owe_beat(ST_OK, key, 1'b1);
          end
        end
      end
      CMD_DUMP: begin
        n_dump++;
        if (held_cnt == 0) begin
          n_dump_empty++;
          owe_beat(ST_EMPTY, key, 1'b1);
        end else begin
          for (int i = 0; i < held_cnt; i++) owe_beat(ST_OK, held_vals[i], i + 1 == held_cnt);
        end
      end
      default: n_spare++;   // spare code: no beat, store untouched
    endcase
  endfunction

  function automatic void add_cmd(logic [1:0] op, logic [31:0] val, logic drain);
    list_cmd_t c;
    c.cmd     = op;
    c.operand = val;
    c.drain   = drain;
    pending_cmds.push_back(c);
    if (op == CMD_APPEND) begin
      appended_pool.push_back(val);
      if (appended_pool.size() > 24) void'(appended_pool.pop_front());
    end
  endfunction

  // operand mix: small values for duplicates, full random, extremes, recent appends
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 7) - 3;
      4, 5, 6:    v = $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: begin
        if (appended_pool.size() != 0)
          v = appended_pool[$urandom_range(0, appended_pool.size() - 1)];
        else
          v = $urandom;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------- driver
  int  gap_left = 0;
  int  gap_pct  = 20;
  logic      drv_took;
  list_cmd_t drv_next;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drv_took = in_valid_i && !in_stall_o;
      if (drv_took) begin
        list_apply(cmd_i, operand_value_i);
        cmds_taken++;
        // change the idling density now and then, zero gives gap-free stretches
        if (cmds_taken % 32 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 50;
          endcase
        end
        if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
          gap_left = $urandom_range(1, 9);
      end
      // a beat on offer stays put until taken; only then may a new one go out
      if (!in_valid_i || drv_took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain || owed_beats.size() == 0)) begin
          drv_next = pending_cmds.pop_front();
          cmd_i           <= drv_next.cmd;
          operand_value_i <= drv_next.operand;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int  stall_left = 0;
  int  hold_left  = 0;
  int  stall_pct  = 15;
  int  mon_cycles = 0;
  bit  long_hold_done = 1'b0;
  list_beat_t mon_want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      mon_cycles++;
      if (out_valid_o && !out_stall_i) begin
        beats_seen++;
        if (owed_beats.size() == 0) begin
          $error("unexpected beat: status %0d value %0d last %0b",
                 status_o, entry_value_o, last_of_run_o);
          errors++;
        end else begin
          mon_want = owed_beats.pop_front();
          if (status_o !== mon_want.status) begin
            $error("status mismatch: expected %0d, got %0d", mon_want.status, status_o);
            errors++;
          end
          if (entry_value_o !== $signed(mon_want.value)) begin
            $error("entry_value mismatch: expected %0d, got %0d",
                   $signed(mon_want.value), entry_value_o);
            errors++;
          end
          if (last_of_run_o !== mon_want.last) begin
            $error("last_of_run mismatch: expected %0b, got %0b", mon_want.last, last_of_run_o);
            errors++;
          end
        end
      end
      if (mon_cycles % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      // one long hold-off while the sender keeps offering, so the block backs up
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && cmds_taken >= 100) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        out_stall_i   <= 1'b1;
      end else if (pending_cmds.size() < QUIET_TAIL) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left  = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d beats still owed",
                 idle_cycles, owed_beats.size());
        $display("ordered_list_append_delete verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run
  initial begin
    int          del_heavy;
    int          roll;
    logic [31:0] key;

    // directed: empty cases, field extremes, duplicates, miss, spare code
    add_cmd(CMD_DUMP,   32'h1234_5678, 1'b0);   // dump of an empty store
    add_cmd(CMD_DELETE, 32'h0000_0001, 1'b0);   // delete on an empty store
    add_cmd(CMD_APPEND, 32'h8000_0000, 1'b0);
    add_cmd(CMD_APPEND, 32'h7fff_ffff, 1'b0);
    add_cmd(CMD_APPEND, 32'h0000_0000, 1'b0);
    add_cmd(CMD_APPEND, 32'hffff_ffff, 1'b0);
    add_cmd(CMD_APPEND, 32'd5,         1'b0);
    add_cmd(CMD_APPEND, 32'd5,         1'b0);
    add_cmd(CMD_DELETE, 32'd5,         1'b0);   // duplicate: only the first goes
    add_cmd(CMD_DELETE, 32'd12345,     1'b0);   // key not held
    add_cmd(CMD_SPARE,  32'hdead_beef, 1'b0);
    // fill to capacity, then one append too many and a full-length dump
    for (int i = 0; i < 11; i++) add_cmd(CMD_APPEND, 32'd100 + i, 1'b0);
    add_cmd(CMD_APPEND, 32'd999,       1'b0);
    add_cmd(CMD_DUMP,   32'h0,         1'b0);
    add_cmd(CMD_DELETE, 32'd110,       1'b0);   // tail entry
    add_cmd(CMD_DELETE, 32'h8000_0000, 1'b0);   // head entry

    // random: phases lean toward append or delete so the store sweeps full and empty
    del_heavy = 0;
    for (int k = 0; k < RAND_CMDS; k++) begin
      if (k % 40 == 0) del_heavy = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (roll < (del_heavy ? 20 : 60)) begin
        add_cmd(CMD_APPEND, pick_value(), k == 150);
      end else if (roll < 80) begin
        if (appended_pool.size() != 0 && $urandom_range(0, 9) < 7)
          key = appended_pool[$urandom_range(0, appended_pool.size() - 1)];
        else
          key = pick_value();
        add_cmd(CMD_DELETE, key, k == 150);
      end else if (roll < 95) begin
        add_cmd(CMD_DUMP, $urandom, k == 150);
      end else begin
        add_cmd(CMD_SPARE, $urandom, k == 150);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (owed_beats.size() != 0) begin
      $error("%0d beats never arrived", owed_beats.size());
      errors++;
    end

    $display("run covered %0d commands (%0d append, %0d delete, %0d dump, %0d spare), %0d beats",
             cmds_taken, n_append, n_delete, n_dump, n_spare, beats_seen);
    $display("corner hits: %0d full appends, %0d empty deletes, %0d misses, %0d empty dumps",
             n_full, n_del_empty, n_notfound, n_dump_empty);
    if (errors == 0) begin
      $display("ordered_list_append_delete verification clean");
    end else begin
      $display("ordered_list_append_delete verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/olad_pkg.sv
rtl/core/ordered_list_append_delete.sv
rtl/core/olad_chk.sv
dv/ordered_list_append_delete_tb.sv
